/* design/assert_macros.svh */
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

/* design/cmmns_pkg.sv */
// Package with types, codes and compare helpers for the column min/max scan.
package cmmns_pkg;

  localparam logic [2:0] TYPE_INT8   = 3'd0;
  localparam logic [2:0] TYPE_INT16  = 3'd1;
  localparam logic [2:0] TYPE_INT32  = 3'd2;
  localparam logic [2:0] TYPE_INT64  = 3'd3;
  localparam logic [2:0] TYPE_FLOAT  = 3'd4;
  localparam logic [2:0] TYPE_DOUBLE = 3'd5;
  localparam logic [2:0] TYPE_RESET  = TYPE_INT32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic [63:0] value;
    logic        valid;
    logic        last;
  } row_t;

  typedef struct packed {
    logic        present;
    logic [63:0] min_bits;
    logic [63:0] max_bits;
    logic        null_seen;
  } stats_t;

  // Classified item: value as an order key plus flags.
  typedef struct packed {
    logic [63:0] value;
    logic [64:0] key;
    logic        is_nan;
    logic        is_zero;
    logic        is_float;
    logic        use_row;
    logic        is_null;
    logic        last;
  } item_t;

  function automatic logic [63:0] type_mask(input logic [2:0] t);
    unique case (t)
      TYPE_INT8:  type_mask = {56'd0, BYTE_MASK};
      TYPE_INT16: type_mask = {48'd0, {2{BYTE_MASK}}};
      TYPE_INT32, TYPE_FLOAT: type_mask = {32'd0, {4{BYTE_MASK}}};
      default:    type_mask = {8{BYTE_MASK}};
    endcase
  endfunction

  function automatic logic [63:0] type_sign(input logic [2:0] t);
    unique case (t)
      TYPE_INT8:  type_sign = 64'h80;
      TYPE_INT16: type_sign = 64'h8000;
      TYPE_INT32, TYPE_FLOAT: type_sign = 64'h8000_0000;
      default:    type_sign = 64'h8000_0000_0000_0000;
    endcase
  endfunction

  // Unsigned order key of raw bits under type t; bits above the type width are kept, but cleared for negative floats.
  function automatic logic [63:0] order_key(input logic [63:0] x, input logic [2:0] t);
    logic [63:0] sb;
    logic [63:0] m;
    sb = type_sign(t);
    m  = type_mask(t);
    if (t == TYPE_FLOAT || t == TYPE_DOUBLE) begin
      order_key = ((x & sb) != 64'd0) ? (~x & m) : (x | sb);
    end else begin
      order_key = x ^ sb;
    end
  endfunction

endpackage

/* design/cmmns_stream_if.sv */
// Valid/ready stream interfaces for rows and statistics.
interface cmmns_row_if import cmmns_pkg::*; ();
  logic valid;
  logic ready;
  row_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cmmns_stats_if import cmmns_pkg::*; ();
  logic   valid;
  logic   ready;
  stats_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/column_min_max_null_scan.sv */
// A row enters a two-entry queue, from which the back end pops it when the output slot is free or drains.
// A last row's statistics are registered and presented in the cycle after the back end pops it.
// Throughput: one row per cycle while the statistics output is not stalled.
// Reset (synchronous, active high) clears queue, running state, output and sets value_type to int32.
// Top level of the column min/max/null scan.
module column_min_max_null_scan import cmmns_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_wdata,
  cmmns_row_if.sink     row_in,
  cmmns_stats_if.source stats_out
);
  logic [2:0] value_type;
  logic       q_valid, q_pop;
  item_t      q_item;

  always_ff @(posedge clk) begin
    if (rst) value_type <= TYPE_RESET;
    else if (cfg_we) value_type <= cfg_wdata;
  end

  cmmns_front u_front (.clk, .rst, .value_type, .row_in, .q_valid, .q_item, .q_pop);
  cmmns_back  u_back  (.clk, .rst, .value_type, .q_valid, .q_item, .q_pop, .stats_out);
endmodule

/* design/cmmns_front.sv */
// Front end: accepts rows, masks and classifies them, and queues them.
module cmmns_front import cmmns_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  value_type,
  cmmns_row_if.sink   row_in,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);
  item_t       cls;
  item_t       slots [QUEUE_DEPTH];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic [63:0] m, sb, v, mag;
  logic [63:0] expo;
  logic        push;

  always_comb begin
    m    = type_mask(value_type);
    sb   = type_sign(value_type);
    v    = row_in.data.value & m;
    mag  = v & ~sb;
    expo = (value_type == TYPE_FLOAT) ? 64'h7F80_0000 : 64'h7FF0_0000_0000_0000;
    cls.value    = v;
    cls.is_float = (value_type == TYPE_FLOAT) || (value_type == TYPE_DOUBLE);
    cls.is_nan   = cls.is_float && (mag > expo);
    cls.is_zero  = cls.is_float && (mag == 64'd0);
    if (cls.is_float) begin
      cls.key = {1'b0, ((v & sb) != 64'd0) ? (~v & m) : (v | sb)};
    end else begin
      cls.key = {1'b0, v ^ sb};
    end
    cls.use_row = row_in.data.valid && (value_type <= TYPE_DOUBLE);
    cls.is_null = !row_in.data.valid;
    cls.last    = row_in.data.last;
  end

  assign row_in.ready = (count != 2'd2);
  assign push    = row_in.valid && row_in.ready;
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cls;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

`include "assert_macros.svh"
  `ASSERT_CLK(a_no_overflow, clk, rst, count <= 2'd2)
  `ASSERT_CLK(a_pop_nonempty, clk, rst, q_pop |-> q_valid)
  `ASSERT_CLK(a_count_track, clk, rst, (push && !q_pop && count == 2'd1) |=> count == 2'd2)
endmodule

/* design/cmmns_back.sv */
// Back end: updates running min/max state and emits statistics on the last row.
module cmmns_back import cmmns_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [2:0]    value_type,
  input  logic          q_valid,
  input  item_t         q_item,
  output logic          q_pop,
  cmmns_stats_if.source stats_out
);
  logic        seen_valid, any_null;
  logic [63:0] running_min, running_max;
  logic [64:0] min_key, max_key;
  logic        min_nan, max_nan, min_zero, max_zero;
  logic        less_min, greater_max;
  logic        out_valid;
  stats_t      out_data;
  logic        seen_next, null_next;
  logic [63:0] m, sb, expo, min_mag, max_mag;
  logic        out_bits_zero;

  // A transaction can leave the queue whenever the output slot is free or drains now.
  assign q_pop = q_valid && (!out_valid || stats_out.ready);
  assign stats_out.valid = out_valid;
  assign stats_out.data  = out_data;
  assign out_bits_zero = (out_data.min_bits == 64'd0) && (out_data.max_bits == 64'd0);

  // The stored extremes are compared under the type in force now, as they are stored.
  always_comb begin
    m        = type_mask(value_type);
    sb       = type_sign(value_type);
    expo     = (value_type == TYPE_FLOAT) ? 64'h7F80_0000 : 64'h7FF0_0000_0000_0000;
    min_mag  = running_min & ~sb & m;
    max_mag  = running_max & ~sb & m;
    min_key  = {1'b0, order_key(running_min, value_type)};
    max_key  = {1'b0, order_key(running_max, value_type)};
    min_nan  = min_mag > expo;
    max_nan  = max_mag > expo;
    min_zero = min_mag == 64'd0;
    max_zero = max_mag == 64'd0;
    less_min    = q_item.key < min_key;
    greater_max = max_key < q_item.key;
    if (q_item.is_float) begin
      if (q_item.is_nan || min_nan || (q_item.is_zero && min_zero)) less_min = 1'b0;
      if (q_item.is_nan || max_nan || (q_item.is_zero && max_zero)) greater_max = 1'b0;
    end
    seen_next = seen_valid || q_item.use_row;
    null_next = any_null || q_item.is_null;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_valid  <= 1'b0;
      any_null    <= 1'b0;
      out_valid   <= 1'b0;
      running_min <= 64'd0;
      running_max <= 64'd0;
    end else begin
      if (out_valid && stats_out.ready) out_valid <= 1'b0;
      if (q_pop) begin
        if (q_item.last) begin
          out_valid          <= 1'b1;
          out_data.present   <= seen_next;
          out_data.null_seen <= null_next;
          if (q_item.use_row && !seen_valid) begin
            out_data.min_bits <= q_item.value;
            out_data.max_bits <= q_item.value;
          end else begin
            out_data.min_bits <= (q_item.use_row && less_min) ? q_item.value : running_min;
            out_data.max_bits <= (q_item.use_row && greater_max) ? q_item.value : running_max;
          end
          seen_valid  <= 1'b0;
          any_null    <= 1'b0;
          running_min <= 64'd0;
          running_max <= 64'd0;
        end else begin
          seen_valid <= seen_next;
          any_null   <= null_next;
          if (q_item.use_row) begin
            if (!seen_valid) begin
              running_min <= q_item.value;
              running_max <= q_item.value;
            end else begin
              if (less_min) running_min <= q_item.value;
              if (greater_max) running_max <= q_item.value;
            end
          end
        end
      end
    end
  end

`include "assert_macros.svh"
  `ASSERT_CLK(a_out_hold, clk, rst, (out_valid && !stats_out.ready) |=> out_valid)
  `ASSERT_CLK(a_clear_after_last, clk, rst, (q_pop && q_item.last) |=> (!seen_valid && !any_null))
  `ASSERT_CLK(a_zero_when_absent, clk, rst, (out_valid && !out_data.present) |-> out_bits_zero)
endmodule

/* tb/column_min_max_null_scan_tb.sv */
// Self-checking testbench for the column min/max/null scan block.
`timescale 1ns / 1ps

module testbench;
  import cmmns_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_wdata;

  cmmns_row_if row_bus ();
  cmmns_stats_if stats_bus ();

  column_min_max_null_scan u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .row_in    (row_bus.sink),
    .stats_out (stats_bus.source)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  row_t   pending_rows[$];
  stats_t expected_stats[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_cycles;
  int unsigned error_count;
  int unsigned cycle_count;

  // Predictor state.
  logic [2:0]  col_type;
  logic        col_seen;
  logic [63:0] col_min;
  logic [63:0] col_max;
  logic        col_null;

  function automatic logic [63:0] width_mask(input logic [2:0] t);
    case (t)
      TYPE_INT8:  return 64'hFF;
      TYPE_INT16: return 64'hFFFF;
      TYPE_INT32, TYPE_FLOAT: return 64'hFFFF_FFFF;
      default:    return '1;
    endcase
  endfunction

  function automatic logic [63:0] sign_bit(input logic [2:0] t);
    case (t)
      TYPE_INT8:  return 64'h80;
      TYPE_INT16: return 64'h8000;
      TYPE_INT32, TYPE_FLOAT: return 64'h8000_0000;
      default:    return 64'h8000_0000_0000_0000;
    endcase
  endfunction

  function automatic logic strictly_less(input logic [63:0] a, input logic [63:0] b,
                                         input logic [2:0] t);
    logic [63:0] sb;
    logic [63:0] m;
    logic [63:0] expo;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] ka;
    logic [63:0] kb;
    sb = sign_bit(t);
    m = width_mask(t);
    if (t == TYPE_FLOAT || t == TYPE_DOUBLE) begin
      expo = (t == TYPE_FLOAT) ? 64'h7F80_0000 : 64'h7FF0_0000_0000_0000;
      ma = a & ~sb & m;
      mb = b & ~sb & m;
      if (ma > expo || mb > expo) return 1'b0;
      if (ma == 0 && mb == 0) return 1'b0;
      ka = (a & sb) != 0 ? (~a & m) : (a | sb);
      kb = (b & sb) != 0 ? (~b & m) : (b | sb);
      return ka < kb;
    end
    return (a ^ sb) < (b ^ sb);
  endfunction

  task automatic predict_row(input row_t r);
    logic [63:0] v;
    stats_t s;
    if (!r.valid) begin
      col_null = 1'b1;
    end else if (col_type <= TYPE_DOUBLE) begin
      v = r.value & width_mask(col_type);
      if (!col_seen) begin
        col_min = v;
        col_max = v;
        col_seen = 1'b1;
      end else begin
        if (strictly_less(v, col_min, col_type)) col_min = v;
        if (strictly_less(col_max, v, col_type)) col_max = v;
      end
    end
    if (r.last) begin
      s.present = col_seen;
      s.min_bits = col_seen ? col_min : 64'd0;
      s.max_bits = col_seen ? col_max : 64'd0;
      s.null_seen = col_null;
      expected_stats = {expected_stats, s};
      col_seen = 1'b0;
      col_min = '0;
      col_max = '0;
      col_null = 1'b0;
    end
  endtask

  // Driver: offers queued rows, predicting each one when its transaction completes.
  always @(posedge clk) begin
    if (rst) begin
      row_bus.valid <= 1'b0;
      row_bus.data <= '0;
    end else begin
      if (row_bus.valid && row_bus.ready) begin
        predict_row(row_bus.data);
        void'(pending_rows.pop_front());
      end
      if ((!row_bus.valid || row_bus.ready) ) begin
        if ((row_bus.valid && row_bus.ready ? pending_rows.size() > 0 : pending_rows.size() > 0)
            && $urandom_range(99) >= send_idle_pct) begin
          row_bus.valid <= 1'b1;
          row_bus.data <= pending_rows[0];
        end else begin
          row_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Counts down a long stretch in which the receiver holds off.
  always @(posedge clk) begin
    if (!rst && hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  // Monitor: compares each statistics transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      stats_bus.ready <= 1'b0;
    end else begin
      if (stats_bus.valid && stats_bus.ready) begin
        if (expected_stats.size() == 0) begin
          $error("unexpected statistics transaction");
          error_count++;
        end else begin
          if (stats_bus.data.present !== expected_stats[0].present) begin
            $error("stats_present expected %0h actual %0h",
                   expected_stats[0].present, stats_bus.data.present);
            error_count++;
          end
          if (stats_bus.data.min_bits !== expected_stats[0].min_bits) begin
            $error("min_bits expected %h actual %h",
                   expected_stats[0].min_bits, stats_bus.data.min_bits);
            error_count++;
          end
          if (stats_bus.data.max_bits !== expected_stats[0].max_bits) begin
            $error("max_bits expected %h actual %h",
                   expected_stats[0].max_bits, stats_bus.data.max_bits);
            error_count++;
          end
          if (stats_bus.data.null_seen !== expected_stats[0].null_seen) begin
            $error("null_seen expected %0h actual %0h",
                   expected_stats[0].null_seen, stats_bus.data.null_seen);
            error_count++;
          end
          void'(expected_stats.pop_front());
        end
      end
      if (hold_off_cycles > 0) begin
        stats_bus.ready <= 1'b0;
      end else begin
        stats_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** column_min_max_null_scan: FAILED **");
      $finish;
    end
  end

  function automatic logic [63:0] random_value(input logic [2:0] t);
    logic [63:0] v;
    logic [63:0] sb;
    v = {$urandom, $urandom};
    sb = sign_bit(t);
    case ($urandom_range(9))
      0: v = sb;
      1: v = sb - 1;
      2: v = 64'd0;
      3: v = sb;
      4: v = (t == TYPE_FLOAT) ? 64'h7FC0_0000 : 64'h7FF8_0000_0000_0000;
      5: v = (t == TYPE_FLOAT) ? 64'h7F80_0000 : 64'hFFF0_0000_0000_0000;
      6: v = v & 64'hF;
      default: ;
    endcase
    // Random upper bits beyond the type width must be ignored.
    if ($urandom_range(1) == 0) v = v | ({$urandom, $urandom} & ~width_mask(t));
    return v;
  endfunction

  task automatic add_row(input logic [63:0] v, input logic valid, input logic last);
    row_t r;
    r.value = v;
    r.valid = valid;
    r.last = last;
    pending_rows = {pending_rows, r};
  endtask

  task automatic wait_idle();
    while (pending_rows.size() > 0 || row_bus.valid || expected_stats.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_type(input logic [2:0] t);
    cfg_we <= 1'b1;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    col_type = t;
    @(posedge clk);
  endtask

  task automatic random_columns(input logic [2:0] t, input int unsigned n_rows);
    int unsigned i;
    int unsigned len;
    i = 0;
    while (i < n_rows) begin
      len = $urandom_range(1, 8);
      repeat (len) begin
        add_row(random_value(t), $urandom_range(4) != 0, 1'b0);
        i++;
      end
      add_row(random_value(t), $urandom_range(4) != 0, 1'b1);
      i++;
    end
  endtask

  initial begin
    logic [2:0] t;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    error_count = 0;
    cycle_count = 0;
    col_type = TYPE_RESET;
    col_seen = 1'b0;
    col_min = '0;
    col_max = '0;
    col_null = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset type int32 with extremes, an empty column, a null last row.
    add_row(64'hFFFF_FFFF_8000_0000, 1'b1, 1'b0);
    add_row(64'h7FFF_FFFF, 1'b1, 1'b0);
    add_row(64'd0, 1'b0, 1'b1);
    add_row(64'd5, 1'b0, 1'b1);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    wait_idle();
    // Float: a NaN seed is kept; signed zeros compare equal.
    write_type(TYPE_FLOAT);
    add_row(64'h7FC0_0000, 1'b1, 1'b0);
    add_row(64'h3F80_0000, 1'b1, 1'b1);
    add_row(64'h8000_0000, 1'b1, 1'b0);
    add_row(64'h0000_0000, 1'b1, 1'b0);
    add_row(64'hFF80_0000, 1'b1, 1'b0);
    add_row(64'h7F80_0000, 1'b1, 1'b0);
    add_row(64'h7FC0_0001, 1'b1, 1'b1);
    wait_idle();
    write_type(TYPE_DOUBLE);
    add_row(64'h8000_0000_0000_0000, 1'b1, 1'b0);
    add_row(64'h0000_0000_0000_0000, 1'b1, 1'b0);
    add_row(64'hFFF8_0000_0000_0000, 1'b1, 1'b1);
    wait_idle();
    // Unused type codes drop valid rows but still record nulls.
    write_type(3'd7);
    add_row(64'd9, 1'b1, 1'b0);
    add_row(64'd1, 1'b0, 1'b1);
    wait_idle();
    write_type(3'd6);
    add_row(64'd9, 1'b1, 1'b1);
    wait_idle();
    // Type change inside one column.
    write_type(TYPE_INT8);
    add_row(64'hFF, 1'b1, 1'b0);
    add_row(64'h7F, 1'b1, 1'b0);
    wait_idle();
    write_type(TYPE_INT64);
    add_row(64'h8000_0000_0000_0000, 1'b1, 1'b1);
    wait_idle();

    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      t = (phase < 6) ? 3'(phase) : 3'($urandom_range(7));
      write_type(t);
      if (phase == 8) hold_off_cycles = 200;
      random_columns(t, 34);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("** column_min_max_null_scan: PASSED **");
    end else begin
      $display("** column_min_max_null_scan: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/cmmns_pkg.sv
design/cmmns_stream_if.sv
design/cmmns_front.sv
design/cmmns_back.sv
design/column_min_max_null_scan.sv
tb/column_min_max_null_scan_tb.sv
